>>> design/asd_pkg.sv
`timescale 1ns / 1ps

package asd_pkg;

    localparam int ACCEL_BITS = 16;
    localparam int TIME_BITS  = 32;

    localparam int SQ_BITS    = 32;
    localparam int GAP_BITS   = 16;
    localparam int TOUT_BITS  = 32;
    localparam int DATA_BITS  = 32;
    localparam int INDEX_BITS = 3;

    localparam int MAG_BITS   = 2 * ACCEL_BITS;
    localparam int SQ_CMP_BITS   = (MAG_BITS > SQ_BITS) ? MAG_BITS : SQ_BITS;
    localparam int GAP_CMP_BITS  = (TIME_BITS > GAP_BITS) ? TIME_BITS : GAP_BITS;
    localparam int TOUT_CMP_BITS = (TIME_BITS > TOUT_BITS) ? TIME_BITS : TOUT_BITS;

    localparam logic [SQ_BITS-1:0]   STEP_HIGH_RESET = 32'd386547056;
    localparam logic [SQ_BITS-1:0]   STEP_LOW_RESET  = 32'd171798692;
    localparam logic [GAP_BITS-1:0]  MIN_GAP_RESET   = 16'd300;
    localparam logic [SQ_BITS-1:0]   MOVE_HIGH_RESET = 32'd355005890;
    localparam logic [SQ_BITS-1:0]   MOVE_LOW_RESET  = 32'd193944617;
    localparam logic [TOUT_BITS-1:0] TIMEOUT_RESET   = 32'd3600000;

    typedef enum logic [INDEX_BITS-1:0] {
        REG_STEP_HIGH_SQ     = 3'd0,
        REG_STEP_LOW_SQ      = 3'd1,
        REG_MIN_STEP_GAP_MS  = 3'd2,
        REG_MOVE_HIGH_SQ     = 3'd3,
        REG_MOVE_LOW_SQ      = 3'd4,
        REG_STILL_TIMEOUT_MS = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [SQ_BITS-1:0]   step_high_sq;
        logic [SQ_BITS-1:0]   step_low_sq;
        logic [GAP_BITS-1:0]  min_step_gap_ms;
        logic [SQ_BITS-1:0]   move_high_sq;
        logic [SQ_BITS-1:0]   move_low_sq;
        logic [TOUT_BITS-1:0] still_timeout_ms;
    } t_cfg;

    typedef struct packed {
        logic signed [ACCEL_BITS-1:0] accel_x;
        logic signed [ACCEL_BITS-1:0] accel_y;
        logic signed [ACCEL_BITS-1:0] accel_z;
        logic [TIME_BITS-1:0]         time_ms;
    } t_sample;

    typedef struct packed {
        logic step_count;
        logic moving;
        logic asleep;
    } t_result;

endpackage

>>> design/asd_sample_if.sv
`timescale 1ns / 1ps

interface asd_sample_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [asd_pkg::ACCEL_BITS-1:0] accel_x;
    logic signed [asd_pkg::ACCEL_BITS-1:0] accel_y;
    logic signed [asd_pkg::ACCEL_BITS-1:0] accel_z;
    logic [asd_pkg::TIME_BITS-1:0]        time_ms;

    modport source (output valid, output accel_x, output accel_y, output accel_z,
                    output time_ms, input ready);
    modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                    input time_ms, output ready);
endinterface

>>> design/asd_result_if.sv
`timescale 1ns / 1ps

interface asd_result_if;
    logic valid;
    logic ready;
    logic step_count;
    logic moving;
    logic asleep;

    modport source (output valid, output step_count, output moving, output asleep,
                    input ready);
    modport sink   (input valid, input step_count, input moving, input asleep,
                    output ready);
endinterface

>>> design/accel_step_and_stillness_detector.sv
`timescale 1ns / 1ps

// Step and stillness detector for a three-axis accelerometer.
// Input channel i_sample carries one request per sample: signed x, y, z
// at 16384 LSB per g and a wrapping millisecond timestamp. Output channel
// o_result returns one request per sample: step_count, moving, asleep.
// Both channels move a request on a clock edge with valid and ready high.
// Throughput is one sample per cycle while the receiver keeps ready high.
// A sample is held in the input register, the squared magnitude and all
// compares are evaluated combinationally between that register and the
// result register; the detector state updates as the result is written.
// When the receiver stalls, the result register holds and one more sample
// waits in the input register; ready then drops until the result drains.
// Thresholds must be written on the i_cfg_we port only while no sample is
// in flight; the block itself does not enforce this.
// Synchronous active-low reset restores the default thresholds, clears the
// armed step, last step time and stillness state, and empties both
// registers.

module accel_step_and_stillness_detector (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [asd_pkg::INDEX_BITS-1:0]   i_cfg_index,
    input  logic [asd_pkg::DATA_BITS-1:0]    i_cfg_wdata,
    asd_sample_if.sink                       i_sample,
    asd_result_if.source                     o_result
);

    asd_pkg::t_cfg                 cfg;
    asd_pkg::t_sample              r_sample;
    logic                          r_in_valid;
    asd_pkg::t_result              r_result;
    logic                          r_out_valid;
    asd_pkg::t_result              n_result;
    logic [asd_pkg::MAG_BITS-1:0]  mag_sq;
    logic                          advance;
    logic                          take;

    assign advance = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_sample.ready = !r_in_valid || advance;
    assign take = i_sample.valid && i_sample.ready;

    asd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    asd_mag u_mag (
        .i_sample (r_sample),
        .o_mag_sq (mag_sq)
    );

    asd_detect u_detect (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (advance),
        .i_cfg     (cfg),
        .i_mag_sq  (mag_sq),
        .i_time_ms (r_sample.time_ms),
        .o_result  (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_sample.accel_x <= i_sample.accel_x;
            r_sample.accel_y <= i_sample.accel_y;
            r_sample.accel_z <= i_sample.accel_z;
            r_sample.time_ms <= i_sample.time_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.step_count = r_result.step_count;
    assign o_result.moving     = r_result.moving;
    assign o_result.asleep     = r_result.asleep;

endmodule

>>> design/asd_cfg.sv
`timescale 1ns / 1ps

module asd_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [asd_pkg::INDEX_BITS-1:0]   i_cfg_index,
    input  logic [asd_pkg::DATA_BITS-1:0]    i_cfg_wdata,
    output asd_pkg::t_cfg                    o_cfg
);

    asd_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_high_sq     <= asd_pkg::STEP_HIGH_RESET;
            r_cfg.step_low_sq      <= asd_pkg::STEP_LOW_RESET;
            r_cfg.min_step_gap_ms  <= asd_pkg::MIN_GAP_RESET;
            r_cfg.move_high_sq     <= asd_pkg::MOVE_HIGH_RESET;
            r_cfg.move_low_sq      <= asd_pkg::MOVE_LOW_RESET;
            r_cfg.still_timeout_ms <= asd_pkg::TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                asd_pkg::REG_STEP_HIGH_SQ:
                    r_cfg.step_high_sq <= i_cfg_wdata[asd_pkg::SQ_BITS-1:0];
                asd_pkg::REG_STEP_LOW_SQ:
                    r_cfg.step_low_sq <= i_cfg_wdata[asd_pkg::SQ_BITS-1:0];
                asd_pkg::REG_MIN_STEP_GAP_MS:
                    r_cfg.min_step_gap_ms <= i_cfg_wdata[asd_pkg::GAP_BITS-1:0];
                asd_pkg::REG_MOVE_HIGH_SQ:
                    r_cfg.move_high_sq <= i_cfg_wdata[asd_pkg::SQ_BITS-1:0];
                asd_pkg::REG_MOVE_LOW_SQ:
                    r_cfg.move_low_sq <= i_cfg_wdata[asd_pkg::SQ_BITS-1:0];
                asd_pkg::REG_STILL_TIMEOUT_MS:
                    r_cfg.still_timeout_ms <= i_cfg_wdata[asd_pkg::TOUT_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> design/asd_mag.sv
`timescale 1ns / 1ps

module asd_mag (
    input  asd_pkg::t_sample               i_sample,
    output logic [asd_pkg::MAG_BITS-1:0]   o_mag_sq
);

    localparam int PROD_BITS = 2 * asd_pkg::ACCEL_BITS;

    logic signed [PROD_BITS-1:0] sq_x;
    logic signed [PROD_BITS-1:0] sq_y;
    logic signed [PROD_BITS-1:0] sq_z;

    always_comb begin
        sq_x = PROD_BITS'(i_sample.accel_x) * PROD_BITS'(i_sample.accel_x);
        sq_y = PROD_BITS'(i_sample.accel_y) * PROD_BITS'(i_sample.accel_y);
        sq_z = PROD_BITS'(i_sample.accel_z) * PROD_BITS'(i_sample.accel_z);
    end

    assign o_mag_sq = asd_pkg::MAG_BITS'($unsigned(sq_x))
                    + asd_pkg::MAG_BITS'($unsigned(sq_y))
                    + asd_pkg::MAG_BITS'($unsigned(sq_z));

endmodule

>>> design/asd_detect.sv
`timescale 1ns / 1ps

module asd_detect (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_fire,
    input  asd_pkg::t_cfg                    i_cfg,
    input  logic [asd_pkg::MAG_BITS-1:0]     i_mag_sq,
    input  logic [asd_pkg::TIME_BITS-1:0]    i_time_ms,
    output asd_pkg::t_result                 o_result
);

    localparam int SQW = asd_pkg::SQ_CMP_BITS;
    localparam int GPW = asd_pkg::GAP_CMP_BITS;
    localparam int TOW = asd_pkg::TOUT_CMP_BITS;

    logic                          r_step_armed;
    logic [asd_pkg::TIME_BITS-1:0] r_last_step_time;
    logic                          r_still_valid;
    logic [asd_pkg::TIME_BITS-1:0] r_still_start_time;

    logic                          n_step_armed;
    logic [asd_pkg::TIME_BITS-1:0] n_last_step_time;
    logic                          n_still_valid;
    logic [asd_pkg::TIME_BITS-1:0] n_still_start_time;

    logic [SQW-1:0]                mag;
    logic [asd_pkg::TIME_BITS-1:0] step_gap;
    logic [asd_pkg::TIME_BITS-1:0] still_span;
    logic                          gap_ok;
    logic                          moving;
    logic                          stepped;
    logic                          asleep;

    always_comb begin
        mag        = SQW'(i_mag_sq);
        step_gap   = i_time_ms - r_last_step_time;
        still_span = i_time_ms - r_still_start_time;
        gap_ok     = GPW'(step_gap) > GPW'(i_cfg.min_step_gap_ms);
        moving     = (mag > SQW'(i_cfg.move_high_sq)) || (mag < SQW'(i_cfg.move_low_sq));

        n_step_armed     = r_step_armed;
        n_last_step_time = r_last_step_time;
        stepped          = 1'b0;
        if (!r_step_armed && (mag > SQW'(i_cfg.step_high_sq))) begin
            n_step_armed = 1'b1;
        end else if (r_step_armed && (mag < SQW'(i_cfg.step_low_sq))) begin
            n_step_armed = 1'b0;
            if (gap_ok) begin
                stepped          = 1'b1;
                n_last_step_time = i_time_ms;
            end
        end

        n_still_valid      = !moving;
        n_still_start_time = r_still_start_time;
        if (!moving && !r_still_valid) begin
            n_still_start_time = i_time_ms;
        end
        asleep = !moving && r_still_valid
               && (TOW'(still_span) > TOW'(i_cfg.still_timeout_ms));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_armed       <= 1'b0;
            r_last_step_time   <= '0;
            r_still_valid      <= 1'b0;
            r_still_start_time <= '0;
        end else if (i_fire) begin
            r_step_armed       <= n_step_armed;
            r_last_step_time   <= n_last_step_time;
            r_still_valid      <= n_still_valid;
            r_still_start_time <= n_still_start_time;
        end
    end

    assign o_result.step_count = stepped;
    assign o_result.moving     = moving;
    assign o_result.asleep     = asleep;

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int          ITEMS_PER_PHASE = 225;
    localparam int          LATENCY         = 2;
    localparam int          CYCLE_LIMIT     = 200000;
    localparam int          IDLE_LIGHT      = 15;
    localparam int          IDLE_HEAVY      = 45;
    localparam int          MAX_PRINTED     = 40;
    localparam logic [31:0] SQ_LIMIT        = 32'd3221225472;

    localparam logic [asd_pkg::INDEX_BITS-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [asd_pkg::INDEX_BITS-1:0] REG_SPARE_7 = 3'd7;

    typedef enum int {MAG_STILL, MAG_HIGH, MAG_LOW, MAG_NOISE} t_mag_kind;
    typedef enum int {
        CFG_DEFAULT, CFG_ZERO, CFG_MAX, CFG_SWAPPED, CFG_TYPICAL, CFG_ANY, CFG_SHORT_TIMEOUT
    } t_cfg_set;

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_cfg_we    = 1'b0;
    logic [asd_pkg::INDEX_BITS-1:0] i_cfg_index = '0;
    logic [asd_pkg::DATA_BITS-1:0]  i_cfg_wdata = '0;

    asd_sample_if smp ();
    asd_result_if res ();

    accel_step_and_stillness_detector DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_sample    (smp),
        .o_result    (res)
    );

    asd_pkg::t_cfg  thresholds;
    logic           step_armed;
    logic [31:0]    last_step_ms;
    logic           still_seen;
    logic [31:0]    still_since_ms;

    asd_pkg::t_sample sample_q[$];
    asd_pkg::t_result flags_due[$];
    asd_pkg::t_sample sample_on_wire;
    asd_pkg::t_result oldest_flags;
    int             sender_idle_pct;
    int             receiver_idle_pct;
    int             error_count = 0;
    int unsigned    cycle_count = 0;

    logic [31:0]    clock_ms;
    logic [31:0]    stride_ms;
    int             batch_count;

    t_cfg_set phase_plan[7] = '{CFG_DEFAULT, CFG_ZERO, CFG_MAX, CFG_SWAPPED,
                                CFG_TYPICAL, CFG_ANY, CFG_SHORT_TIMEOUT};

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [31:0] axis_sq(input logic signed [asd_pkg::ACCEL_BITS-1:0] a);
        logic signed [31:0] wide;
        wide = a;
        return wide * wide;
    endfunction

    function automatic asd_pkg::t_result predict_flags(input asd_pkg::t_sample s);
        logic [33:0]      mag_sq;
        logic [31:0]      since_step;
        logic [31:0]      since_still;
        asd_pkg::t_result r;
        mag_sq = 34'(axis_sq(s.accel_x)) + 34'(axis_sq(s.accel_y)) + 34'(axis_sq(s.accel_z));
        r.moving = (mag_sq > 34'(thresholds.move_high_sq)) ||
                   (mag_sq < 34'(thresholds.move_low_sq));
        r.step_count = 1'b0;
        if (!step_armed && mag_sq > 34'(thresholds.step_high_sq)) begin
            step_armed = 1'b1;
        end else if (step_armed && mag_sq < 34'(thresholds.step_low_sq)) begin
            since_step = s.time_ms - last_step_ms;
            if (since_step > 32'(thresholds.min_step_gap_ms)) begin
                r.step_count = 1'b1;
                last_step_ms = s.time_ms;
            end
            step_armed = 1'b0;
        end
        if (r.moving) begin
            still_seen = 1'b0;
            r.asleep = 1'b0;
        end else begin
            if (!still_seen) begin
                still_seen = 1'b1;
                still_since_ms = s.time_ms;
            end
            since_still = s.time_ms - still_since_ms;
            r.asleep = since_still > thresholds.still_timeout_ms;
        end
        return r;
    endfunction

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTED) $display("ERROR at %0t: %s", $time, msg);
    endtask

    task automatic check_flag(input string name, input logic got, input logic want);
        if (got !== want) report_error($sformatf("%s got %b want %b", name, got, want));
    endtask

    // push the expected flags when a request is accepted, then offer the next one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            smp.valid <= 1'b0;
        end else begin
            if (smp.valid && smp.ready) flags_due.push_back(predict_flags(sample_on_wire));
            if (!smp.valid || smp.ready) begin
                if (sample_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    sample_on_wire = sample_q.pop_front();
                    smp.valid   <= 1'b1;
                    smp.accel_x <= sample_on_wire.accel_x;
                    smp.accel_y <= sample_on_wire.accel_y;
                    smp.accel_z <= sample_on_wire.accel_z;
                    smp.time_ms <= sample_on_wire.time_ms;
                end else begin
                    smp.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res.ready <= 1'b0;
        end else begin
            if (res.valid && res.ready) begin
                if (flags_due.size() == 0) begin
                    report_error("result with no request outstanding");
                end else begin
                    oldest_flags = flags_due.pop_front();
                    check_flag("step_count", res.step_count, oldest_flags.step_count);
                    check_flag("moving", res.moving, oldest_flags.moving);
                    check_flag("asleep", res.asleep, oldest_flags.asleep);
                end
            end
            res.ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("accel_step_and_stillness_detector: mismatch");
            $finish;
        end
    end

    task automatic write_reg(input logic [asd_pkg::INDEX_BITS-1:0] idx,
                             input logic [31:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        case (idx)
            asd_pkg::REG_STEP_HIGH_SQ:     thresholds.step_high_sq     = data;
            asd_pkg::REG_STEP_LOW_SQ:      thresholds.step_low_sq      = data;
            asd_pkg::REG_MIN_STEP_GAP_MS:
                thresholds.min_step_gap_ms = data[asd_pkg::GAP_BITS-1:0];
            asd_pkg::REG_MOVE_HIGH_SQ:     thresholds.move_high_sq     = data;
            asd_pkg::REG_MOVE_LOW_SQ:      thresholds.move_low_sq      = data;
            asd_pkg::REG_STILL_TIMEOUT_MS: thresholds.still_timeout_ms = data;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic program_thresholds(input t_cfg_set setting);
        case (setting)
            CFG_ZERO: begin
                write_reg(asd_pkg::REG_STEP_HIGH_SQ, '0);
                write_reg(asd_pkg::REG_STEP_LOW_SQ, '0);
                write_reg(asd_pkg::REG_MIN_STEP_GAP_MS, '0);
                write_reg(asd_pkg::REG_MOVE_HIGH_SQ, '0);
                write_reg(asd_pkg::REG_MOVE_LOW_SQ, '0);
                write_reg(asd_pkg::REG_STILL_TIMEOUT_MS, '0);
            end
            CFG_MAX: begin
                write_reg(asd_pkg::REG_STEP_HIGH_SQ, SQ_LIMIT);
                write_reg(asd_pkg::REG_STEP_LOW_SQ, SQ_LIMIT);
                write_reg(asd_pkg::REG_MIN_STEP_GAP_MS, 32'hFFFF_FFFF);
                write_reg(asd_pkg::REG_MOVE_HIGH_SQ, SQ_LIMIT);
                write_reg(asd_pkg::REG_MOVE_LOW_SQ, SQ_LIMIT);
                write_reg(asd_pkg::REG_STILL_TIMEOUT_MS, 32'hFFFF_FFFF);
                write_reg(REG_SPARE_6, $urandom());
                write_reg(REG_SPARE_7, $urandom());
            end
            CFG_SWAPPED: begin
                write_reg(asd_pkg::REG_STEP_HIGH_SQ, asd_pkg::STEP_LOW_RESET);
                write_reg(asd_pkg::REG_STEP_LOW_SQ, asd_pkg::STEP_HIGH_RESET);
                write_reg(asd_pkg::REG_MIN_STEP_GAP_MS, 32'h0001_0005);
                write_reg(asd_pkg::REG_MOVE_HIGH_SQ, asd_pkg::MOVE_LOW_RESET);
                write_reg(asd_pkg::REG_MOVE_LOW_SQ, asd_pkg::MOVE_HIGH_RESET);
                write_reg(asd_pkg::REG_STILL_TIMEOUT_MS, 32'd1);
            end
            CFG_TYPICAL: begin
                write_reg(asd_pkg::REG_STEP_HIGH_SQ, $urandom_range(600000000, 250000000));
                write_reg(asd_pkg::REG_STEP_LOW_SQ, $urandom_range(250000000, 50000000));
                write_reg(asd_pkg::REG_MIN_STEP_GAP_MS, $urandom_range(400, 0));
                write_reg(asd_pkg::REG_MOVE_HIGH_SQ, $urandom_range(400000000, 268435456));
                write_reg(asd_pkg::REG_MOVE_LOW_SQ, $urandom_range(268435456, 150000000));
                write_reg(asd_pkg::REG_STILL_TIMEOUT_MS, $urandom_range(20000, 0));
            end
            CFG_ANY: begin
                write_reg(asd_pkg::REG_STEP_HIGH_SQ, $urandom_range(SQ_LIMIT, 0));
                write_reg(asd_pkg::REG_STEP_LOW_SQ, $urandom_range(SQ_LIMIT, 0));
                write_reg(asd_pkg::REG_MIN_STEP_GAP_MS, $urandom());
                write_reg(asd_pkg::REG_MOVE_HIGH_SQ, $urandom_range(SQ_LIMIT, 0));
                write_reg(asd_pkg::REG_MOVE_LOW_SQ, $urandom_range(SQ_LIMIT, 0));
                write_reg(asd_pkg::REG_STILL_TIMEOUT_MS, $urandom());
                write_reg(REG_SPARE_7, $urandom());
            end
            CFG_SHORT_TIMEOUT: begin
                write_reg(asd_pkg::REG_STEP_HIGH_SQ, asd_pkg::STEP_HIGH_RESET);
                write_reg(asd_pkg::REG_STEP_LOW_SQ, asd_pkg::STEP_LOW_RESET);
                write_reg(asd_pkg::REG_MIN_STEP_GAP_MS, 32'(asd_pkg::MIN_GAP_RESET));
                write_reg(asd_pkg::REG_MOVE_HIGH_SQ, asd_pkg::MOVE_HIGH_RESET);
                write_reg(asd_pkg::REG_MOVE_LOW_SQ, asd_pkg::MOVE_LOW_RESET);
                write_reg(asd_pkg::REG_STILL_TIMEOUT_MS, $urandom_range(3000, 500));
            end
            default: ;
        endcase
    endtask

    task automatic queue_raw(input int x, input int y, input int z, input logic [31:0] t);
        asd_pkg::t_sample s;
        s.accel_x = asd_pkg::ACCEL_BITS'(x);
        s.accel_y = asd_pkg::ACCEL_BITS'(y);
        s.accel_z = asd_pkg::ACCEL_BITS'(z);
        s.time_ms = t;
        clock_ms  = t;
        sample_q.push_back(s);
    endtask

    task automatic queue_kind(input t_mag_kind kind, input logic [31:0] dt);
        int main_mag;
        int axis;
        int a[3];
        asd_pkg::t_sample s;
        case (kind)
            MAG_STILL: main_mag = $urandom_range(17800, 15000);
            MAG_HIGH:  main_mag = $urandom_range(32767, 19000);
            MAG_LOW:   main_mag = $urandom_range(13000, 0);
            default:   main_mag = 0;
        endcase
        foreach (a[i]) a[i] = int'($urandom_range(1200)) - 600;
        axis = $urandom_range(2);
        a[axis] = $urandom_range(1) ? main_mag : -main_mag;
        if (kind == MAG_NOISE) foreach (a[i]) a[i] = $urandom();
        clock_ms  = clock_ms + dt;
        s.accel_x = asd_pkg::ACCEL_BITS'(a[0]);
        s.accel_y = asd_pkg::ACCEL_BITS'(a[1]);
        s.accel_z = asd_pkg::ACCEL_BITS'(a[2]);
        s.time_ms = clock_ms;
        sample_q.push_back(s);
        batch_count++;
    endtask

    // rise above the step limit, fall below it, sometimes right at the minimum gap
    task automatic queue_walk();
        logic [31:0] elapsed;
        repeat ($urandom_range(6, 1)) begin
            repeat ($urandom_range(3, 1)) queue_kind(MAG_HIGH, $urandom_range(80, 0));
            if ($urandom_range(1)) queue_kind(MAG_STILL, $urandom_range(80, 0));
            elapsed = clock_ms - stride_ms;
            if ($urandom_range(3) == 0 && elapsed <= 32'(thresholds.min_step_gap_ms))
                queue_kind(MAG_LOW,
                           32'(thresholds.min_step_gap_ms) + $urandom_range(1) - elapsed);
            else
                queue_kind(MAG_LOW, $urandom_range(250, 10));
            stride_ms = clock_ms;
            if ($urandom_range(1)) queue_kind(MAG_LOW, $urandom_range(60, 0));
        end
    endtask

    // hold still, often landing on the sleep timeout, now and then broken by motion
    task automatic queue_rest();
        logic [31:0] rest_from;
        logic [31:0] elapsed;
        logic [31:0] dt;
        t_mag_kind   kind;
        queue_kind(MAG_STILL, $urandom_range(200, 1));
        rest_from = clock_ms;
        repeat ($urandom_range(16, 3)) begin
            elapsed = clock_ms - rest_from;
            kind = MAG_STILL;
            case ($urandom_range(9))
                0, 1, 2: begin
                    if (elapsed <= thresholds.still_timeout_ms)
                        dt = thresholds.still_timeout_ms - elapsed + $urandom_range(1);
                    else
                        dt = $urandom_range(50, 1);
                end
                3: dt = 0;
                4: dt = $urandom();
                5: begin
                    kind = $urandom_range(1) ? MAG_HIGH : MAG_LOW;
                    dt = $urandom_range(100, 0);
                end
                default: dt = $urandom_range(1000, 1);
            endcase
            queue_kind(kind, dt);
        end
    endtask

    task automatic queue_noise();
        repeat ($urandom_range(5, 1)) begin
            if ($urandom_range(3) == 0) clock_ms = $urandom();
            queue_kind(t_mag_kind'($urandom_range(3)), $urandom_range(400, 0));
        end
    endtask

    task automatic queue_batch(input int n);
        int pick;
        batch_count = 0;
        while (batch_count < n) begin
            pick = $urandom_range(99);
            if (pick < 40) queue_walk();
            else if (pick < 75) queue_rest();
            else queue_noise();
        end
    endtask

    task automatic wait_drained();
        while (sample_q.size() != 0 || smp.valid || flags_due.size() != 0) @(negedge i_clk);
        repeat (LATENCY) @(negedge i_clk);
    endtask

    initial begin
        smp.valid   = 1'b0;
        smp.accel_x = '0;
        smp.accel_y = '0;
        smp.accel_z = '0;
        smp.time_ms = '0;
        res.ready   = 1'b0;
        thresholds  = '{asd_pkg::STEP_HIGH_RESET, asd_pkg::STEP_LOW_RESET,
                        asd_pkg::MIN_GAP_RESET, asd_pkg::MOVE_HIGH_RESET,
                        asd_pkg::MOVE_LOW_RESET, asd_pkg::TIMEOUT_RESET};
        step_armed        = 1'b0;
        last_step_ms      = '0;
        still_seen        = 1'b0;
        still_since_ms    = '0;
        clock_ms          = '0;
        stride_ms         = '0;
        sender_idle_pct   = IDLE_LIGHT;
        receiver_idle_pct = IDLE_HEAVY;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        queue_raw(0, 0, 0, 32'd0);
        queue_raw(16384, 0, 0, 32'd50);
        queue_raw(-32768, -32768, -32768, 32'd100);
        queue_raw(32767, 32767, 32767, 32'd150);
        queue_raw(0, 0, 16384, 32'd200);
        queue_raw(0, 0, -8192, 32'd250);
        queue_raw(0, 20000, 0, 32'd280);
        queue_raw(0, 0, 0, 32'd301);
        queue_raw(0, -20000, 0, 32'd400);
        queue_raw(5000, 0, 0, 32'd601);
        queue_raw(0, 0, -32768, 32'd700);
        queue_raw(0, 0, 1000, 32'd902);
        queue_raw(16384, 0, 0, 32'd1000);
        queue_raw(0, 16384, 0, 32'd3601000);
        queue_raw(0, 0, -16384, 32'd3601001);
        queue_raw(0, 0, 20000, 32'd3601100);
        queue_raw(0, 0, 16384, 32'd3601200);
        queue_raw(16384, 0, 0, 32'hFFFF_FFF0);
        queue_raw(0, 0, 100, 32'h0000_0010);
        queue_raw(16384, 0, 0, 32'hFFFF_FFF8);
        queue_raw(0, 16384, 0, 32'h0036_EE78);
        queue_raw(0, 0, -30000, 32'h0036_EE80);
        queue_raw(0, 0, 0, 32'h0036_EF00);

        foreach (phase_plan[k]) begin
            wait_drained();
            program_thresholds(phase_plan[k]);
            @(negedge i_clk);
            if (k == 2) begin
                sender_idle_pct   = IDLE_HEAVY;
                receiver_idle_pct = IDLE_LIGHT;
            end else if (k == 5) begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            queue_batch(ITEMS_PER_PHASE);
        end

        wait_drained();
        if (error_count == 0) begin
            $display("accel_step_and_stillness_detector: match");
        end else begin
            $display("accel_step_and_stillness_detector: mismatch");
        end
        $finish;
    end

endmodule

>>> accel_step_and_stillness_detector.f
design/asd_pkg.sv
design/asd_sample_if.sv
design/asd_result_if.sv
design/asd_cfg.sv
design/asd_mag.sv
design/asd_detect.sv
design/accel_step_and_stillness_detector.sv
tb/sv/tb_top.sv
